// ===== sv/oqc_pkg.sv =====
// Package: shared types and constants for the opposite quadrant coincidence block.
`timescale 1ns / 1ps
`default_nettype none
package oqc_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_HIT   = 1'b1
  } oqc_op_e;

  typedef enum logic [0:0] {
    REG_CALIB  = 1'b0,
    REG_WINDOW = 1'b1
  } oqc_reg_e;

  localparam int unsigned CALIB_W  = 16;
  localparam int unsigned WINDOW_W = 24;
  localparam int unsigned CFG_W    = 24;

  localparam logic [CALIB_W-1:0]  CALIB_RESET  = 16'd6400;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd196608;

  localparam logic [1:0] OPPOSITE_MASK = 2'b10;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;

  typedef struct packed {
    logic       is_start;
    logic       last;
    logic [1:0] quadrant;
    logic       in_win;
  } oqc_ctl_t;

endpackage
`default_nettype wire

// ===== sv/opposite_quadrant_coincidence_top.sv =====
// Top level: configuration registers, front end, word queue and back end.
// The verdict goes through the front-end register, the word queue and the result register.
// Throughput: one word per cycle unless full; the back end takes one queued word per cycle.
// A word with last set waits at the queue head while the single result register is held.
// Reset: asynchronous, active low; registers return to 6400 and 3 ns, queues empty,
// reference time zero, no quadrant seen.
`timescale 1ns / 1ps
`default_nettype none
module opposite_quadrant_coincidence_top import oqc_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_idx_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               operation_i,
  input  wire logic signed [15:0] ref_count_i,
  input  wire logic signed [31:0] hit_time_i,
  input  wire logic [1:0]         quadrant_i,
  input  wire logic               last_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    is_coincidence_o
);

  localparam int unsigned QW = $bits(oqc_ctl_t) + TIME_WIDTH;

  logic [CALIB_W-1:0]            calib_q;
  logic [WINDOW_W-1:0]           window_q;
  logic                          f_push, f_full, f_pop, f_empty;
  oqc_ctl_t                      f_ctl, b_ctl;
  logic signed [TIME_WIDTH-1:0]  f_time, b_time;
  logic [QW-1:0]                 b_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q  <= CALIB_RESET;
      window_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      case (oqc_reg_e'(cfg_idx_i))
        REG_CALIB:  calib_q  <= cfg_data_i[CALIB_W-1:0];
        REG_WINDOW: window_q <= cfg_data_i[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  oqc_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .calib_i     (calib_q),
    .window_i    (window_q),
    .push_i      (push),
    .full_o      (full),
    .operation_i (operation_i),
    .ref_count_i (ref_count_i),
    .hit_time_i  (hit_time_i),
    .quadrant_i  (quadrant_i),
    .last_i      (last_i),
    .q_push_o    (f_push),
    .q_full_i    (f_full),
    .q_ctl_o     (f_ctl),
    .q_time_o    (f_time)
  );

  oqc_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i ({f_ctl, f_time}),
    .full_o  (f_full),
    .pop_i   (f_pop),
    .rdata_o (b_word),
    .empty_o (f_empty)
  );

  assign b_ctl  = oqc_ctl_t'(b_word[QW-1:TIME_WIDTH]);
  assign b_time = $signed(b_word[TIME_WIDTH-1:0]);

  oqc_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .window_i         (window_q),
    .q_empty_i        (f_empty),
    .q_pop_o          (f_pop),
    .q_ctl_i          (b_ctl),
    .q_time_i         (b_time),
    .empty_o          (empty),
    .pop_i            (pop),
    .is_coincidence_o (is_coincidence_o)
  );

endmodule
`default_nettype wire

// ===== sv/oqc_front.sv =====
// Front end: accept words, scale the reference, saturate times, classify hits against the window.
`timescale 1ns / 1ps
`default_nettype none
module oqc_front import oqc_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [CALIB_W-1:0]            calib_i,
  input  wire logic [WINDOW_W-1:0]           window_i,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic                          operation_i,
  input  wire logic signed [15:0]            ref_count_i,
  input  wire logic signed [31:0]            hit_time_i,
  input  wire logic [1:0]                    quadrant_i,
  input  wire logic                          last_i,
  output logic                               q_push_o,
  input  wire logic                          q_full_i,
  output oqc_ctl_t                           q_ctl_o,
  output logic signed [TIME_WIDTH-1:0]       q_time_o
);

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned XW = (TW > 33) ? TW : 33;
  localparam int unsigned CW = (TW + 1 > WINDOW_W + 1) ? TW + 1 : WINDOW_W + 1;
  localparam logic signed [XW-1:0] TMAX = XW'({1'b0, {(TW-1){1'b1}}});
  localparam logic signed [XW-1:0] TMIN = ~TMAX;

  function automatic logic signed [TW-1:0] sat_t(input logic signed [XW-1:0] v);
    logic signed [TW-1:0] r;
    if (v > TMAX) begin
      r = {1'b0, {(TW-1){1'b1}}};
    end else if (v < TMIN) begin
      r = {1'b1, {(TW-1){1'b0}}};
    end else begin
      r = TW'(v);
    end
    return r;
  endfunction

  logic                   s1_v_q, s1_v_d;
  logic                   s1_start_q, s1_last_q;
  logic [1:0]             s1_quad_q;
  logic signed [XW-1:0]   s1_val_q, s1_val_d;
  logic signed [TW-1:0]   ref_q, ref_d;
  logic signed [32:0]     prod;
  logic signed [XW-1:0]   hit_ext;
  logic signed [TW-1:0]   t2;
  logic signed [CW-1:0]   diff, wext;
  logic                   accept, advance;

  assign full_o   = s1_v_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = s1_v_q && !q_full_i;
  assign advance  = q_push_o;

  assign prod    = ref_count_i * $signed({1'b0, calib_i});
  assign hit_ext = XW'(hit_time_i);

  always_comb begin
    if (operation_i == OP_HIT) begin
      s1_val_d = XW'(sat_t(hit_ext));
    end else begin
      s1_val_d = XW'(prod);
    end
  end

  always_comb begin
    if (accept) begin
      s1_v_d = 1'b1;
    end else if (advance) begin
      s1_v_d = 1'b0;
    end else begin
      s1_v_d = s1_v_q;
    end
  end

  assign t2   = s1_start_q ? sat_t(s1_val_q) : TW'(s1_val_q);
  assign wext = $signed(CW'(window_i));
  assign diff = CW'(t2) - CW'(ref_q);

  assign ref_d = (advance && s1_start_q) ? t2 : ref_q;

  always_comb begin
    q_ctl_o.is_start = s1_start_q;
    q_ctl_o.last     = s1_last_q;
    q_ctl_o.quadrant = s1_quad_q;
    q_ctl_o.in_win   = !s1_start_q && (diff <= wext) && (diff >= -wext);
    q_time_o         = t2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      ref_q  <= '0;
    end else begin
      s1_v_q <= s1_v_d;
      ref_q  <= ref_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_start_q <= (operation_i == OP_START);
      s1_last_q  <= last_i;
      s1_quad_q  <= quadrant_i;
      s1_val_q   <= s1_val_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/oqc_fifo.sv =====
// Short word queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module oqc_fifo import oqc_pkg::*; #(
  parameter int unsigned WIDTH = 37
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0]      mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_PTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (FIFO_PTR_W+1)'(push_i) - (FIFO_PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/oqc_back.sv =====
// Back end: per-quadrant extremes, pair test, event verdict and result register.
`timescale 1ns / 1ps
`default_nettype none
module oqc_back import oqc_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [WINDOW_W-1:0]     window_i,
  input  wire logic                    q_empty_i,
  output logic                         q_pop_o,
  input  wire oqc_ctl_t                q_ctl_i,
  input  wire logic signed [TIME_WIDTH-1:0] q_time_i,
  output logic                         empty_o,
  input  wire logic                    pop_i,
  output logic                         is_coincidence_o
);

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned CW = (TW + 1 > WINDOW_W + 1) ? TW + 1 : WINDOW_W + 1;

  logic signed [TW-1:0] min_q [4];
  logic signed [TW-1:0] max_q [4];
  logic [3:0]           seen_q, seen_d, seen_new;
  logic                 pair_q, pair_d, pair_new, pair_hit;
  logic                 out_v_q, out_v_d, out_q;
  logic                 go, hit, out_pop;
  logic [1:0]           opp;
  logic [3:0]           lane_near;
  logic signed [CW-1:0] wext;

  assign wext    = $signed(CW'(window_i));
  assign out_pop = pop_i && out_v_q;
  assign go      = !q_empty_i && (!q_ctl_i.last || !out_v_q || out_pop);
  assign q_pop_o = go;
  assign hit     = !q_ctl_i.is_start;
  assign opp     = q_ctl_i.quadrant ^ OPPOSITE_MASK;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic signed [CW-1:0] dmin, dmax;
    logic                 upd;

    assign dmin = CW'(q_time_i) - CW'(min_q[k]);
    assign dmax = CW'(q_time_i) - CW'(max_q[k]);
    assign lane_near[k] = ((dmin <= wext) && (dmin >= -wext)) ||
                          ((dmax <= wext) && (dmax >= -wext));
    assign upd = go && hit && q_ctl_i.in_win && (q_ctl_i.quadrant == 2'(k));

    always_ff @(posedge clk_i) begin
      if (upd) begin
        if (!seen_q[k] || (q_time_i < min_q[k])) begin
          min_q[k] <= q_time_i;
        end
        if (!seen_q[k] || (q_time_i > max_q[k])) begin
          max_q[k] <= q_time_i;
        end
      end
    end
  end

  always_comb begin
    pair_hit = hit && q_ctl_i.in_win && seen_q[opp] && lane_near[opp];
    pair_new = hit && (pair_q || pair_hit);
    if (q_ctl_i.is_start) begin
      seen_new = '0;
    end else if (q_ctl_i.in_win) begin
      seen_new = seen_q | (4'b0001 << q_ctl_i.quadrant);
    end else begin
      seen_new = seen_q;
    end
    seen_d = seen_q;
    pair_d = pair_q;
    if (go) begin
      seen_d = q_ctl_i.last ? '0 : seen_new;
      pair_d = q_ctl_i.last ? 1'b0 : pair_new;
    end
    out_v_d = (out_v_q && !out_pop) || (go && q_ctl_i.last);
  end

  assign empty_o          = !out_v_q;
  assign is_coincidence_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      pair_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      seen_q  <= seen_d;
      pair_q  <= pair_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && q_ctl_i.last) begin
      out_q <= pair_new;
    end
  end

endmodule
`default_nettype wire

// ===== sv/oqc_checker.sv =====
// Checker: port-level properties of the coincidence block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module oqc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic push,
  input wire logic full,
  input wire logic last_i,
  input wire logic empty,
  input wire logic pop,
  input wire logic is_coincidence_o
);

  localparam logic [3:0] MAX_PENDING = 4'd6;

  logic [3:0] pend_q, pend_d;
  logic       in_last, out_word;

  assign in_last  = push && !full && last_i;
  assign out_word = pop && !empty;
  assign pend_d   = pend_q + 4'(in_last) - 4'(out_word);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pend_q != 4'd0))
    else $error("result word without a pending last word");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= MAX_PENDING)
    else $error("more pending events than the block can hold");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result word dropped before pop");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(is_coincidence_o))
    else $error("result word changed while waiting");

endmodule

bind opposite_quadrant_coincidence_top oqc_checker u_oqc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .push             (push),
  .full             (full),
  .last_i           (last_i),
  .empty            (empty),
  .pop              (pop),
  .is_coincidence_o (is_coincidence_o)
);
`default_nettype wire

// ===== bench/tb_opposite_quadrant_coincidence_top.sv =====
// Testbench: opposite quadrant coincidence block, directed table then random events vs predictor.
`timescale 1ns / 1ps
module tb_opposite_quadrant_coincidence_top;
  import oqc_pkg::*;

  localparam int TIME_W = 32;

  typedef struct packed {
    oqc_op_e     op;
    logic [15:0] ref_count;
    logic [31:0] hit_time;
    logic [1:0]  quadrant;
    logic        last;
  } oqc_word_t;

  typedef struct packed {
    oqc_word_t word;
    bit        typed;
    bit        verdict;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [0:0]         cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;
  logic               push;
  logic               full;
  logic               operation_i;
  logic signed [15:0] ref_count_i;
  logic signed [31:0] hit_time_i;
  logic [1:0]         quadrant_i;
  logic               last_i;
  logic               empty;
  logic               pop;
  logic               is_coincidence_o;

  logic [CALIB_W-1:0]  calib_q;
  logic [WINDOW_W-1:0] window_q;
  longint              ref_time;
  bit [3:0]            seen;
  longint              tmin [4];
  longint              tmax [4];
  bit                  paired;

  bit        verdict_q [$];
  stim_row_t rows [$];
  int        mismatch_count = 0;
  bit        tx_burst = 1'b0;
  bit        rx_burst = 1'b0;

  opposite_quadrant_coincidence_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .operation_i      (operation_i),
    .ref_count_i      (ref_count_i),
    .hit_time_i       (hit_time_i),
    .quadrant_i       (quadrant_i),
    .last_i           (last_i),
    .empty            (empty),
    .pop              (pop),
    .is_coincidence_o (is_coincidence_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint clamp_time(input longint v);
    longint hi;
    hi = (longint'(1) << (TIME_W - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic bit in_window(input longint a, input longint b);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return d <= longint'(window_q);
  endfunction

  function automatic void clear_event();
    seen = '0;
    paired = 1'b0;
    for (int i = 0; i < 4; i++) begin
      tmin[i] = 0;
      tmax[i] = 0;
    end
  endfunction

  function automatic void track_coincidence(input oqc_word_t w, output bit has_verdict,
                                            output bit verdict);
    longint     t;
    logic [1:0] q;
    logic [1:0] o;
    if (w.op == OP_START) begin
      clear_event();
      ref_time = clamp_time(longint'($signed(w.ref_count)) * longint'(calib_q));
    end else begin
      t = clamp_time(longint'($signed(w.hit_time)));
      q = w.quadrant;
      o = q ^ OPPOSITE_MASK;
      if (in_window(t, ref_time)) begin
        if (seen[o] && (in_window(t, tmin[o]) || in_window(t, tmax[o]))) paired = 1'b1;
        if (!seen[q]) begin
          seen[q] = 1'b1;
          tmin[q] = t;
          tmax[q] = t;
        end else begin
          if (t < tmin[q]) tmin[q] = t;
          if (t > tmax[q]) tmax[q] = t;
        end
      end
    end
    has_verdict = w.last;
    verdict = paired;
    if (w.last) clear_event();
  endfunction

  function automatic oqc_word_t noise_word();
    oqc_word_t w;
    w.op = oqc_op_e'($urandom_range(0, 1));
    w.ref_count = 16'($urandom);
    w.hit_time = $urandom;
    w.quadrant = 2'($urandom_range(0, 3));
    w.last = 1'($urandom_range(0, 1));
    return w;
  endfunction

  task automatic send_word(input oqc_word_t w, input bit typed, input bit typed_verdict);
    int gap;
    bit accepted;
    bit has_verdict;
    bit verdict;
    gap = tx_burst ? 0 : idle_cycles();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    operation_i <= w.op;
    ref_count_i <= w.ref_count;
    hit_time_i <= w.hit_time;
    quadrant_i <= w.quadrant;
    last_i <= w.last;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk_i);
      accepted = !full;
      @(posedge clk_i);
    end
    track_coincidence(w, has_verdict, verdict);
    if (has_verdict) verdict_q = {verdict_q, (typed ? typed_verdict : verdict)};
  endtask

  task automatic settle();
    push <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input oqc_reg_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_CALIB) calib_q = data[CALIB_W-1:0];
    else window_q = data[WINDOW_W-1:0];
  endtask

  task automatic add_row(input oqc_op_e op, input logic [15:0] refc, input logic [31:0] ht,
                         input logic [1:0] q, input logic last, input bit typed,
                         input bit verdict);
    stim_row_t r;
    r.word.op = op;
    r.word.ref_count = refc;
    r.word.hit_time = ht;
    r.word.quadrant = q;
    r.word.last = last;
    r.typed = typed;
    r.verdict = verdict;
    rows = {rows, r};
  endtask

  task automatic build_table();
    // hits before any start use reference zero
    add_row(OP_HIT,   16'd0,  32'd0,       2'd0, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  32'd100000,  2'd2, 1'b1, 1'b1, 1'b1);
    add_row(OP_START, 16'd0,  32'd0,       2'd0, 1'b1, 1'b1, 1'b0);
    // window bounds included, one past excluded
    add_row(OP_START, 16'd10, 32'd0,       2'd0, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  32'd260608,  2'd1, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  32'd64000,   2'd3, 1'b1, 1'b1, 1'b1);
    add_row(OP_START, 16'd10, 32'd0,       2'd0, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  32'd260609,  2'd1, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  32'd64000,   2'd3, 1'b1, 1'b1, 1'b0);
    // same and adjacent quadrants never pair
    add_row(OP_START, 16'd0,  32'd0,       2'd0, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  32'd0,       2'd0, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  32'd10,      2'd0, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  -32'sd5,     2'd1, 1'b1, 1'b1, 1'b0);
    // extreme reference counts and hit times
    add_row(OP_START, 16'h7FFF, 32'd0,     2'd0, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  32'h7FFFFFFF, 2'd0, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  32'd209708800, 2'd3, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  32'd209512192, 2'd1, 1'b1, 1'b0, 1'b0);
    add_row(OP_START, 16'h8000, 32'd0,     2'd0, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  32'h80000000, 2'd2, 1'b1, 1'b1, 1'b0);
    // hits with no start keep the previous reference
    add_row(OP_HIT,   16'd0,  -32'sd209715200, 2'd0, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  -32'sd209518592, 2'd2, 1'b1, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  32'd12345,   2'd1, 1'b1, 1'b1, 1'b0);
    add_row(OP_START, 16'hFFFF, 32'd0,     2'd0, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  -32'sd6400,  2'd2, 1'b0, 1'b0, 1'b0);
    add_row(OP_HIT,   16'd0,  -32'sd203008, 2'd0, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic random_phase(input int quota);
    int          sent;
    int          n_hits;
    int unsigned span;
    longint      prev_t;
    oqc_word_t   w;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 9) == 0) tx_burst = ~tx_burst;
      if ($urandom_range(0, 99) < 85) begin
        w = noise_word();
        w.op = OP_START;
        w.last = ($urandom_range(0, 19) == 0);
        send_word(w, 1'b0, 1'b0);
        sent++;
        if (!w.last) begin
          n_hits = $urandom_range(1, 6);
          span = window_q + 2;
          prev_t = ref_time;
          for (int i = 0; i < n_hits; i++) begin
            w = noise_word();
            w.op = OP_HIT;
            w.last = (i == n_hits - 1);
            case ($urandom_range(0, 9))
              0: ;
              1, 2: w.hit_time = 32'(prev_t + longint'($urandom_range(0, 4)) - 2);
              default: w.hit_time = 32'(ref_time + longint'($urandom_range(0, 2 * span))
                                        - longint'(span));
            endcase
            prev_t = longint'($signed(w.hit_time));
            send_word(w, 1'b0, 1'b0);
            sent++;
          end
        end
      end else begin
        send_word(noise_word(), 1'b0, 1'b0);
        sent++;
      end
    end
  endtask

  initial begin
    logic [15:0]       calib;
    logic [WINDOW_W-1:0] win;
    logic [7:0]        pad;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_CALIB;
    cfg_data_i = '0;
    push = 1'b0;
    operation_i = OP_START;
    ref_count_i = '0;
    hit_time_i = '0;
    quadrant_i = '0;
    last_i = 1'b0;
    calib_q = CALIB_RESET;
    window_q = WINDOW_RESET;
    ref_time = 0;
    clear_event();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    build_table();
    foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].verdict);
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin calib = 16'd0;     win = 24'd0;        end
        1: begin calib = 16'hFFFF;  win = 24'hFFFFFF;   end
        2: begin calib = 16'hFFFF;  win = 24'd0;        end
        3: begin calib = 16'd1;     win = 24'd1;        end
        default: begin
          calib = 16'($urandom);
          win = 24'($urandom_range(0, 24'hFFFFFF));
        end
      endcase
      pad = 8'($urandom);
      write_reg(REG_CALIB, {pad, calib});
      write_reg(REG_WINDOW, win);
      random_phase(280);
    end
    settle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int stall;
    bit got;
    bit val;
    bit want;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
      stall = rx_burst ? 0 : idle_cycles();
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(negedge clk_i);
      got = !empty;
      val = is_coincidence_o;
      @(posedge clk_i);
      if (got) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word, is_coincidence=%0b", val));
        end else begin
          want = verdict_q.pop_front();
          if (val !== want)
            report_mismatch($sformatf("is_coincidence got %0b want %0b", val, want));
        end
      end
    end
  end

endmodule
